// File: hw/rtl/wti_pkg.sv
`timescale 1ns / 1ps
package wti_pkg;

  localparam int MAX_WAYPOINTS_DEF = 16;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int COUNT_W = 5;
  localparam int SLOT_W  = 4;

  typedef logic signed [31:0] coord_t;
  typedef logic [31:0]        stamp_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    stamp_t tm;
  } wp_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec3_t;

  typedef enum logic {
    CFG_WAYPOINT_COUNT = 1'b0,
    CFG_WRAP_TO_START  = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

endpackage

// File: hw/rtl/wti_mem.sv
`timescale 1ns / 1ps
module wti_mem import wti_pkg::*; #(
  parameter int DEPTH = MAX_WAYPOINTS_DEF,
  parameter int AW    = $clog2(MAX_WAYPOINTS_DEF)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  wp_t           wdata,
  input  logic [AW-1:0] raddr,
  output wp_t           rdata
);

  wp_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/wti_div.sv
`timescale 1ns / 1ps
module wti_div import wti_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  stamp_t                   num,
  input  stamp_t                   den,
  output logic                     done,
  output logic [FRACTION_BITS-1:0] quotient
);

  localparam int CW = $clog2(FRACTION_BITS + 1);

  logic          active;
  logic [CW-1:0] cnt;
  stamp_t        rem;
  stamp_t        div;
  logic [32:0]   sh;
  logic          fits;

  // num < den on entry, so rem stays below den
  assign sh   = {rem, 1'b0};
  assign fits = sh >= {1'b0, div};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= CW'(FRACTION_BITS);
        rem    <= num;
        div    <= den;
      end else if (active) begin
        if (fits) begin
          rem <= 32'(sh - {1'b0, div});
        end else begin
          rem <= sh[31:0];
        end
        quotient <= {quotient[FRACTION_BITS-2:0], fits};
        cnt      <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

// File: hw/rtl/wti_blend.sv
`timescale 1ns / 1ps
module wti_blend import wti_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [FRACTION_BITS-1:0] alpha,
  input  vec3_t                    p0,
  input  vec3_t                    p1,
  output logic                     done,
  output vec3_t                    result
);

  localparam int PW = 34 + FRACTION_BITS;

  logic                        active;
  logic                        add_phase;
  logic [1:0]                  sel;
  coord_t                      a_arr [3];
  coord_t                      b_arr [3];
  coord_t                      res   [3];
  coord_t                      a_sel;
  coord_t                      b_sel;
  logic signed [32:0]          diff;
  logic signed [FRACTION_BITS:0] alpha_s;
  logic signed [PW-1:0]        prod_w;
  logic signed [PW-1:0]        prod;

  assign a_arr[0] = p0.x;
  assign a_arr[1] = p0.y;
  assign a_arr[2] = p0.z;
  assign b_arr[0] = p1.x;
  assign b_arr[1] = p1.y;
  assign b_arr[2] = p1.z;

  always_comb begin
    case (sel)
      2'd1:    begin a_sel = a_arr[1]; b_sel = b_arr[1]; end
      2'd2:    begin a_sel = a_arr[2]; b_sel = b_arr[2]; end
      default: begin a_sel = a_arr[0]; b_sel = b_arr[0]; end
    endcase
  end

  assign diff    = {b_sel[31], b_sel} - {a_sel[31], a_sel};
  assign alpha_s = {1'b0, alpha};
  assign prod_w  = diff * alpha_s;

  assign result.x = res[0];
  assign result.y = res[1];
  assign result.z = res[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      add_phase <= 1'b0;
      sel       <= '0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active    <= 1'b1;
        add_phase <= 1'b0;
        sel       <= '0;
      end else if (active) begin
        if (!add_phase) begin
          prod      <= prod_w;
          add_phase <= 1'b1;
        end else begin
          // floor of prod / 2^F, low 32 bits only
          res[sel]  <= a_sel + prod[FRACTION_BITS+31:FRACTION_BITS];
          add_phase <= 1'b0;
          if (sel == 2'd2) begin
            active <= 1'b0;
            done   <= 1'b1;
          end else begin
            sel <= sel + 1'b1;
          end
        end
      end
    end
  end

endmodule

// File: hw/rtl/waypoint_time_interpolator_top.sv
`timescale 1ns / 1ps
// Channel   Handshake             Payload
// config    cfg_write             cfg_addr, cfg_data
// item      start, busy           action, entry_index, load_x/y/z, load_time, sim_time
// result    result_valid          pose_x, pose_y, pose_z, wrapped
//
// A load transaction writes one entry while idle. A query reads the last entry, then scans the
// table one entry per cycle through the single read port, then runs a restoring
// divide for FRACTION_BITS quotient bits, then uses the shared multiplier for each axis in turn.
// Synchronous reset clears control and config (count 0, wrap on); table entries are
// undefined until loaded. Results are pulsed for one cycle on result_valid;
// the receiver cannot stall.
module waypoint_time_interpolator_top import wti_pkg::*; #(
  parameter int MAX_WAYPOINTS = MAX_WAYPOINTS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic               cfg_addr,
  input  logic [COUNT_W-1:0] cfg_data,
  input  logic               start,
  output logic               busy,
  input  logic               action,
  input  logic [SLOT_W-1:0]  entry_index,
  input  coord_t             load_x,
  input  coord_t             load_y,
  input  coord_t             load_z,
  input  stamp_t             load_time,
  input  stamp_t             sim_time,
  output logic               result_valid,
  output coord_t             pose_x,
  output coord_t             pose_y,
  output coord_t             pose_z,
  output logic               wrapped
);

  localparam int AW = $clog2(MAX_WAYPOINTS);
  localparam int CW = $clog2(MAX_WAYPOINTS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRAP_CHK,
    S_WRAP_OUT,
    S_SCAN,
    S_DIVIDE,
    S_BLEND
  } state_t;

  state_t             state;
  logic [COUNT_W-1:0] waypoint_count;
  logic               wrap_to_start;
  logic [CW-1:0]      cnt_sat;
  logic [AW-1:0]      last_idx;
  logic [AW-1:0]      k;
  stamp_t             q_time;
  wp_t                prev;
  wp_t                cur;
  wp_t                rd_data;
  wp_t                wdata;
  logic [AW-1:0]      raddr;
  logic               we;
  logic               seg_hit;
  logic               div_start;
  logic               div_done;
  logic [FRACTION_BITS-1:0] alpha;
  logic               blend_start;
  logic               blend_done;
  vec3_t              p0;
  vec3_t              p1;
  vec3_t              blend_res;

  always_comb begin
    if (32'(waypoint_count) > 32'(MAX_WAYPOINTS)) begin
      cnt_sat = CW'(MAX_WAYPOINTS);
    end else begin
      cnt_sat = CW'(waypoint_count);
    end
  end

  assign busy  = (state != S_IDLE);
  assign we    = (state == S_IDLE) && start && (action == ACT_LOAD) &&
                 (32'(entry_index) < 32'(MAX_WAYPOINTS));
  assign wdata = '{x: load_x, y: load_y, z: load_z, tm: load_time};

  always_comb begin
    unique case (state)
      S_IDLE:     raddr = AW'(cnt_sat - 1'b1);
      S_WRAP_CHK: raddr = '0;
      default:    raddr = k + 1'b1;
    endcase
  end

  assign seg_hit     = (state == S_SCAN) && (k != '0) &&
                       (prev.tm <= q_time) && (q_time < rd_data.tm);
  assign div_start   = seg_hit;
  assign blend_start = (state == S_DIVIDE) && div_done;

  assign p0 = '{x: prev.x, y: prev.y, z: prev.z};
  assign p1 = '{x: cur.x, y: cur.y, z: cur.z};

  wti_mem #(.DEPTH(MAX_WAYPOINTS), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (AW'(entry_index)),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_data)
  );

  wti_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num      (q_time - prev.tm),
    .den      (rd_data.tm - prev.tm),
    .done     (div_done),
    .quotient (alpha)
  );

  wti_blend #(.FRACTION_BITS(FRACTION_BITS)) u_blend (
    .clk    (clk),
    .rst    (rst),
    .start  (blend_start),
    .alpha  (alpha),
    .p0     (p0),
    .p1     (p1),
    .done   (blend_done),
    .result (blend_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      waypoint_count <= '0;
      wrap_to_start  <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_addr)
        CFG_WAYPOINT_COUNT: waypoint_count <= cfg_data;
        CFG_WRAP_TO_START:  wrap_to_start  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      k            <= '0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start && action == ACT_QUERY && cnt_sat != '0) begin
            q_time   <= sim_time;
            last_idx <= AW'(cnt_sat - 1'b1);
            state    <= S_WRAP_CHK;
          end
        end
        S_WRAP_CHK: begin
          k <= '0;
          if (wrap_to_start && q_time > rd_data.tm) begin
            state <= S_WRAP_OUT;
          end else if (last_idx == '0) begin
            state <= S_IDLE;
          end else begin
            state <= S_SCAN;
          end
        end
        S_WRAP_OUT: begin
          pose_x       <= rd_data.x;
          pose_y       <= rd_data.y;
          pose_z       <= rd_data.z;
          wrapped      <= 1'b1;
          result_valid <= 1'b1;
          state        <= S_IDLE;
        end
        S_SCAN: begin
          if (seg_hit) begin
            cur   <= rd_data;
            state <= S_DIVIDE;
          end else if (k == last_idx) begin
            state <= S_IDLE;
          end else begin
            prev <= rd_data;
            k    <= k + 1'b1;
          end
        end
        S_DIVIDE: begin
          if (div_done) begin
            state <= S_BLEND;
          end
        end
        S_BLEND: begin
          if (blend_done) begin
            pose_x       <= blend_res.x;
            pose_y       <= blend_res.y;
            pose_z       <= blend_res.z;
            wrapped      <= 1'b0;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
